// ===== sv/dqt_pkg.sv =====
// Package: widths, lane record and result record of the dual quaternion transform unit.
`default_nettype none
package dqt_pkg;

  localparam int unsigned NumLanes  = 12;   // nine matrix entries, three translations
  localparam int unsigned NumMat    = 9;
  localparam int unsigned QuotW     = 33;   // quotient bits (one extra bit for rounding)
  localparam int unsigned DenW      = 33;   // sum of four squares of Q1.14 values
  localparam int unsigned NumW      = 50;   // signed numerator width
  localparam int unsigned ShiftW    = 66;   // scaled dividend width
  localparam int unsigned MatShift  = 15;   // 2^14 scale plus one rounding bit
  localparam int unsigned TrnShift  = 16;   // 2^15 scale plus one rounding bit

  localparam logic [32:0] MatLim    = 33'd16384;
  localparam logic [32:0] TrnPosLim = 33'h0_7FFF_FFFF;
  localparam logic [32:0] TrnNegLim = 33'h0_8000_0000;

  typedef struct packed {
    logic signed [15:0] real_x;
    logic signed [15:0] real_y;
    logic signed [15:0] real_z;
    logic signed [15:0] real_w;
    logic signed [31:0] dual_x;
    logic signed [31:0] dual_y;
    logic signed [31:0] dual_z;
    logic signed [31:0] dual_w;
  } dq_t;

  typedef struct packed {
    logic              neg;
    logic              sat;
    logic [DenW-1:0]   rem;
    logic [QuotW-1:0]  sh;
  } lane_t;

  typedef struct packed {
    logic [NumMat-1:0][15:0] m;
    logic [2:0][31:0]        t;
  } res_t;

  typedef struct packed {
    logic       en;
    logic       last_valid;
    logic [1:0] count;
  } dqt_stat_t;

endpackage
`default_nettype wire

// ===== sv/dqt_in_if.sv =====
// Input channel: one dual quaternion per transaction.
`default_nettype none
interface dqt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] real_x;
  logic signed [15:0] real_y;
  logic signed [15:0] real_z;
  logic signed [15:0] real_w;
  logic signed [31:0] dual_x;
  logic signed [31:0] dual_y;
  logic signed [31:0] dual_z;
  logic signed [31:0] dual_w;

  modport source (output valid, real_x, real_y, real_z, real_w,
                  dual_x, dual_y, dual_z, dual_w, input ready);
  modport sink   (input valid, real_x, real_y, real_z, real_w,
                  dual_x, dual_y, dual_z, dual_w, output ready);
endinterface
`default_nettype wire

// ===== sv/dqt_out_if.sv =====
// Output channel: rotation matrix and translation per transaction.
`default_nettype none
interface dqt_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00;
  logic signed [15:0] m01;
  logic signed [15:0] m02;
  logic signed [15:0] m10;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m20;
  logic signed [15:0] m21;
  logic signed [15:0] m22;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  trans_x, trans_y, trans_z, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  trans_x, trans_y, trans_z, output ready);
endinterface
`default_nettype wire

// ===== sv/dual_quaternion_to_transform_unit.sv =====
// Pipeline: three front stages, a 33-stage divider and the output queue register.
// Throughput: one transaction per cycle while ready; 33 divider stages, one quotient bit each.
// A two-entry output queue lets input continue while a result waits to be taken.
// Reset: asynchronous, active low; clears all valid bits and the queue, data is not reset.
// Ready drops only when the queue is full, the last stage holds a result and none is taken.
`default_nettype none
module dual_quaternion_to_transform_unit
  import dqt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dqt_in_if.sink    dq_i,
  dqt_out_if.source xf_o
);

  dq_t                  dq;
  dqt_stat_t            stat;
  logic                 f_valid, f_zero, d_valid, d_zero;
  logic [DenW-1:0]      f_den;
  lane_t [NumLanes-1:0] f_lane, d_lane;
  res_t                 res;

  assign dq.real_x = dq_i.real_x;
  assign dq.real_y = dq_i.real_y;
  assign dq.real_z = dq_i.real_z;
  assign dq.real_w = dq_i.real_w;
  assign dq.dual_x = dq_i.dual_x;
  assign dq.dual_y = dq_i.dual_y;
  assign dq.dual_z = dq_i.dual_z;
  assign dq.dual_w = dq_i.dual_w;

  assign dq_i.ready = stat.en;

  dqt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (stat.en),
    .valid_i (dq_i.valid),
    .dq_i    (dq),
    .valid_o (f_valid),
    .zero_o  (f_zero),
    .den_o   (f_den),
    .lane_o  (f_lane)
  );

  dqt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (stat.en),
    .valid_i (f_valid),
    .zero_i  (f_zero),
    .den_i   (f_den),
    .lane_i  (f_lane),
    .valid_o (d_valid),
    .zero_o  (d_zero),
    .lane_o  (d_lane)
  );

  dqt_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .zero_i  (d_zero),
    .lane_i  (d_lane),
    .ready_i (xf_o.ready),
    .valid_o (xf_o.valid),
    .res_o   (res),
    .stat_o  (stat)
  );

  assign xf_o.m00     = res.m[8];
  assign xf_o.m01     = res.m[7];
  assign xf_o.m02     = res.m[6];
  assign xf_o.m10     = res.m[5];
  assign xf_o.m11     = res.m[4];
  assign xf_o.m12     = res.m[3];
  assign xf_o.m20     = res.m[2];
  assign xf_o.m21     = res.m[1];
  assign xf_o.m22     = res.m[0];
  assign xf_o.trans_x = res.t[2];
  assign xf_o.trans_y = res.t[1];
  assign xf_o.trans_z = res.t[0];

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count != 2'd3)
    else $error("output queue count out of range");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !xf_o.valid |-> dq_i.ready)
    else $error("input stalled with empty output queue");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.count == 2'd2 && stat.last_valid && !xf_o.ready) |-> !dq_i.ready)
    else $error("pipeline advanced into a full output queue");

endmodule
`default_nettype wire

// ===== sv/dqt_front.sv =====
// Front end: products, numerator sums, magnitudes and divider setup (three stages).
`default_nettype none
module dqt_front
  import dqt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire dq_t                  dq_i,
  output logic                      valid_o,
  output logic                      zero_o,
  output logic [DenW-1:0]           den_o,
  output lane_t [NumLanes-1:0]      lane_o
);

  // stage 1: products
  logic signed [31:0] sq_q [4];   // xx yy zz ww
  logic signed [31:0] cr_q [6];   // xy wz xz wy yz wx
  logic signed [47:0] tp_q [12];
  logic               v1_q;

  // stage 2: sums
  logic [DenW-1:0]           den2_q;
  logic signed [NumW-1:0]    num_q [NumLanes];
  logic                      v2_q;

  // stage 3: divider setup
  logic [DenW-1:0]           den3_q;
  lane_t [NumLanes-1:0]      lane_q;
  logic                      zero_q;
  logic                      v3_q;

  logic signed [47:0] rx, ry, rz, rw, dx, dy, dz, dw;

  assign rx = 48'(dq_i.real_x);
  assign ry = 48'(dq_i.real_y);
  assign rz = 48'(dq_i.real_z);
  assign rw = 48'(dq_i.real_w);
  assign dx = 48'(dq_i.dual_x);
  assign dy = 48'(dq_i.dual_y);
  assign dz = 48'(dq_i.dual_z);
  assign dw = 48'(dq_i.dual_w);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0] <= 32'(dq_i.real_x * dq_i.real_x);
      sq_q[1] <= 32'(dq_i.real_y * dq_i.real_y);
      sq_q[2] <= 32'(dq_i.real_z * dq_i.real_z);
      sq_q[3] <= 32'(dq_i.real_w * dq_i.real_w);
      cr_q[0] <= 32'(dq_i.real_x * dq_i.real_y);
      cr_q[1] <= 32'(dq_i.real_w * dq_i.real_z);
      cr_q[2] <= 32'(dq_i.real_x * dq_i.real_z);
      cr_q[3] <= 32'(dq_i.real_w * dq_i.real_y);
      cr_q[4] <= 32'(dq_i.real_y * dq_i.real_z);
      cr_q[5] <= 32'(dq_i.real_w * dq_i.real_x);
      tp_q[0]  <= dw * rx;
      tp_q[1]  <= rw * dx;
      tp_q[2]  <= dy * rz;
      tp_q[3]  <= ry * dz;
      tp_q[4]  <= dw * ry;
      tp_q[5]  <= dx * rz;
      tp_q[6]  <= rx * dz;
      tp_q[7]  <= rw * dy;
      tp_q[8]  <= dw * rz;
      tp_q[9]  <= rx * dy;
      tp_q[10] <= rw * dz;
      tp_q[11] <= dx * ry;
    end
  end

  logic signed [NumW-1:0] s0, s1, s2, s3;
  logic signed [NumW-1:0] c0, c1, c2, c3, c4, c5;
  logic signed [NumW-1:0] t [12];

  always_comb begin
    s0 = NumW'(sq_q[0]);
    s1 = NumW'(sq_q[1]);
    s2 = NumW'(sq_q[2]);
    s3 = NumW'(sq_q[3]);
    c0 = NumW'(cr_q[0]);
    c1 = NumW'(cr_q[1]);
    c2 = NumW'(cr_q[2]);
    c3 = NumW'(cr_q[3]);
    c4 = NumW'(cr_q[4]);
    c5 = NumW'(cr_q[5]);
    for (int i = 0; i < 12; i++) begin
      t[i] = NumW'(tp_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den2_q    <= DenW'($unsigned(sq_q[0])) + DenW'($unsigned(sq_q[1]))
                 + DenW'($unsigned(sq_q[2])) + DenW'($unsigned(sq_q[3]));
      num_q[0]  <= s3 + s0 - s1 - s2;
      num_q[1]  <= (c0 - c1) <<< 1;
      num_q[2]  <= (c2 + c3) <<< 1;
      num_q[3]  <= (c0 + c1) <<< 1;
      num_q[4]  <= s3 + s1 - s0 - s2;
      num_q[5]  <= (c4 - c5) <<< 1;
      num_q[6]  <= (c2 - c3) <<< 1;
      num_q[7]  <= (c4 + c5) <<< 1;
      num_q[8]  <= s3 + s2 - s0 - s1;
      num_q[9]  <= t[1] - t[0] - t[2] + t[3];
      num_q[10] <= t[5] - t[4] - t[6] + t[7];
      num_q[11] <= t[9] - t[8] + t[10] - t[11];
    end
  end

  // split the scaled magnitude into the starting remainder and the bits still to shift in
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den3_q <= den2_q;
      zero_q <= (den2_q == '0);
      for (int i = 0; i < NumLanes; i++) begin
        logic [NumW-1:0]   mag;
        logic [ShiftW-1:0] scaled;
        mag    = num_q[i][NumW-1] ? NumW'(-num_q[i]) : NumW'(num_q[i]);
        scaled = (i < NumMat) ? (ShiftW'(mag) << MatShift) : (ShiftW'(mag) << TrnShift);
        lane_q[i].neg <= num_q[i][NumW-1];
        lane_q[i].rem <= scaled[ShiftW-1:QuotW];
        lane_q[i].sh  <= scaled[QuotW-1:0];
        lane_q[i].sat <= (scaled[ShiftW-1:QuotW] >= den2_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign zero_o  = zero_q;
  assign den_o   = den3_q;
  assign lane_o  = lane_q;

endmodule
`default_nettype wire

// ===== sv/dqt_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for all lanes.
`default_nettype none
module dqt_div
  import dqt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic                 zero_i,
  input  wire logic [DenW-1:0]      den_i,
  input  wire lane_t [NumLanes-1:0] lane_i,
  output logic                      valid_o,
  output logic                      zero_o,
  output lane_t [NumLanes-1:0]      lane_o
);

  lane_t [NumLanes-1:0] st_q   [QuotW];
  logic [DenW-1:0]      den_q  [QuotW];
  logic                 zero_q [QuotW];
  logic                 v_q    [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    lane_t [NumLanes-1:0] src;
    logic [DenW-1:0]      src_den;
    logic                 src_zero;
    logic                 src_v;

    if (k == 0) begin : g_first
      assign src      = lane_i;
      assign src_den  = den_i;
      assign src_zero = zero_i;
      assign src_v    = valid_i;
    end else begin : g_next
      assign src      = st_q[k-1];
      assign src_den  = den_q[k-1];
      assign src_zero = zero_q[k-1];
      assign src_v    = v_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= src_den;
        zero_q[k] <= src_zero;
        for (int i = 0; i < NumLanes; i++) begin
          logic [DenW:0] trial;
          logic          qbit;
          trial = {src[i].rem, src[i].sh[QuotW-1]};
          qbit  = (trial >= {1'b0, src_den});
          st_q[k][i].neg <= src[i].neg;
          st_q[k][i].sat <= src[i].sat;
          st_q[k][i].rem <= qbit ? DenW'(trial - {1'b0, src_den}) : trial[DenW-1:0];
          st_q[k][i].sh  <= {src[i].sh[QuotW-2:0], qbit};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= src_v;
      end
    end
  end

  assign valid_o = v_q[QuotW-1];
  assign zero_o  = zero_q[QuotW-1];
  assign lane_o  = st_q[QuotW-1];

endmodule
`default_nettype wire

// ===== sv/dqt_out.sv =====
// Back end: rounding, clamping, sign and a two-entry output queue.
`default_nettype none
module dqt_out
  import dqt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic                 zero_i,
  input  wire lane_t [NumLanes-1:0] lane_i,
  input  wire logic                 ready_i,
  output logic                      valid_o,
  output res_t                      res_o,
  output dqt_stat_t                 stat_o
);

  res_t       res;
  res_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q, count_d;
  logic       push, pop, en;

  always_comb begin
    res = '0;
    for (int i = 0; i < NumLanes; i++) begin
      logic [QuotW:0]   inc;
      logic [QuotW-1:0] rnd;
      logic [QuotW-1:0] lim;
      logic [QuotW-1:0] mag;
      logic [QuotW:0]   sval;
      inc  = {1'b0, lane_i[i].sh} + {{QuotW{1'b0}}, 1'b1};
      rnd  = inc[QuotW:1];
      if (i < NumMat) begin
        lim = MatLim;
      end else begin
        lim = lane_i[i].neg ? TrnNegLim : TrnPosLim;
      end
      mag  = (lane_i[i].sat || (rnd > lim)) ? lim : rnd;
      sval = lane_i[i].neg ? -{1'b0, mag} : {1'b0, mag};
      if (zero_i) begin
        sval = '0;
      end
      if (i < NumMat) begin
        res.m[NumMat-1-i] = sval[15:0];
      end else begin
        res.t[NumLanes-1-i] = sval[31:0];
      end
    end
  end

  assign pop     = valid_o && ready_i;
  // advance while the last stage is empty or the queue has or frees a slot
  assign en      = !valid_i || (count_q != 2'd2) || pop;
  assign push    = valid_i && en;
  assign count_d = count_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      count_q <= count_d;
    end
  end

  assign valid_o           = (count_q != 2'd0);
  assign res_o             = mem_q[rd_q];
  assign stat_o.en         = en;
  assign stat_o.last_valid = valid_i;
  assign stat_o.count      = count_q;

endmodule
`default_nettype wire
